// ----- rtl/hle_pkg.sv -----
// Shared constants, phase codes and result type for the href link extractor.
package hle_pkg;

    localparam int LINK_BUFFER_BYTES = 1024;

    localparam int LEN_W = 10;

    // Scan phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_BASE   = 3'd2;
    localparam logic [2:0] PH_ATTR   = 3'd3;
    localparam logic [2:0] PH_VSTART = 3'd4;
    localparam logic [2:0] PH_VALUE  = 3'd5;

    // Quote modes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_DOUBLE = 2'd1;
    localparam logic [1:0] QM_SINGLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_LINK_LENGTH = 2'd0;
    localparam logic [1:0] REG_TAG_ENABLE      = 2'd1;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_H  = 8'h68;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       has_byte;
        logic       end_of_link;
        logic       tag_kind;
        logic       truncated;
    } result_t;

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            lower_of = c + 8'd32;
        else
            lower_of = c;
    endfunction

    function automatic logic [7:0] href_char(input logic [1:0] idx);
        case (idx)
            2'd0:    href_char = 8'h68;
            2'd1:    href_char = 8'h72;
            2'd2:    href_char = 8'h65;
            default: href_char = 8'h66;
        endcase
    endfunction

    function automatic logic [7:0] base_char(input logic [1:0] idx);
        case (idx)
            2'd0:    base_char = 8'h62;
            2'd1:    base_char = 8'h61;
            2'd2:    base_char = 8'h73;
            default: base_char = 8'h65;
        endcase
    endfunction

    // Length limit in force: zero counts as one, saturate at the buffer size.
    function automatic logic [LEN_W-1:0] limit_of(input logic [LEN_W-1:0] max_len);
        logic [LEN_W:0] l;
        l = {1'b0, max_len};
        if (l == '0)
            l = (LEN_W+1)'(1);
        if (l > (LEN_W+1)'(LINK_BUFFER_BYTES))
            l = (LEN_W+1)'(LINK_BUFFER_BYTES);
        limit_of = l[LEN_W-1:0];
    endfunction

endpackage

// ----- rtl/hle_core.sv -----
// Per-byte tag and href scanner: state registers and next-state/result logic.
module hle_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              page_byte,
    input  logic                    end_of_page,
    input  logic [hle_pkg::LEN_W-1:0] max_link_length,
    input  logic [1:0]              tag_enable,
    output logic                    res_valid,
    output hle_pkg::result_t        res
);

    logic [2:0]               phase_reg, phase_next;
    logic [2:0]               name_cnt_reg, name_cnt_next;
    logic [2:0]               attr_cnt_reg, attr_cnt_next;
    logic [1:0]               quote_reg, quote_next;
    logic                     kind_reg, kind_next;
    logic [hle_pkg::LEN_W-1:0] len_reg, len_next;

    logic [7:0]               lc;
    logic [hle_pkg::LEN_W-1:0] limit;
    logic                     hb, eol, tr, rv;
    logic [7:0]               lb;
    logic                     idle_now;
    logic                     closer;

    assign lc    = hle_pkg::lower_of(page_byte);
    assign limit = hle_pkg::limit_of(max_link_length);

    always_comb
    begin
        phase_next    = phase_reg;
        name_cnt_next = name_cnt_reg;
        attr_cnt_next = attr_cnt_reg;
        quote_next    = quote_reg;
        kind_next     = kind_reg;
        len_next      = len_reg;
        rv            = 1'b0;
        hb            = 1'b0;
        eol           = 1'b0;
        tr            = 1'b0;
        lb            = 8'd0;
        idle_now      = 1'b0;
        closer        = 1'b0;

        unique case (phase_reg)
            hle_pkg::PH_IDLE:
            begin
                if (page_byte == hle_pkg::CH_LT)
                    phase_next = hle_pkg::PH_NAME;
            end
            hle_pkg::PH_NAME:
            begin
                if (lc == hle_pkg::CH_LOW_A && tag_enable[0])
                begin
                    kind_next     = 1'b0;
                    attr_cnt_next = 3'd0;
                    phase_next    = hle_pkg::PH_ATTR;
                end
                else if (lc == hle_pkg::CH_LOW_B && tag_enable[1])
                begin
                    name_cnt_next = 3'd1;
                    phase_next    = hle_pkg::PH_BASE;
                end
                else if (page_byte != hle_pkg::CH_LT)
                    idle_now = 1'b1;
            end
            hle_pkg::PH_BASE:
            begin
                if (name_cnt_reg < 3'd4 && lc == hle_pkg::base_char(name_cnt_reg[1:0]))
                begin
                    name_cnt_next = name_cnt_reg + 3'd1;
                    if (name_cnt_reg == 3'd3)
                    begin
                        kind_next     = 1'b1;
                        attr_cnt_next = 3'd0;
                        phase_next    = hle_pkg::PH_ATTR;
                    end
                end
                else if (page_byte == hle_pkg::CH_LT)
                begin
                    name_cnt_next = 3'd0;
                    phase_next    = hle_pkg::PH_NAME;
                end
                else
                    idle_now = 1'b1;
            end
            hle_pkg::PH_ATTR:
            begin
                if (page_byte == hle_pkg::CH_GT)
                    idle_now = 1'b1;
                else if (attr_cnt_reg < 3'd4 && lc == hle_pkg::href_char(attr_cnt_reg[1:0]))
                    attr_cnt_next = attr_cnt_reg + 3'd1;
                else if (attr_cnt_reg >= 3'd4 && page_byte == hle_pkg::CH_EQ)
                begin
                    phase_next = hle_pkg::PH_VSTART;
                    len_next   = '0;
                end
                else
                    attr_cnt_next = (lc == hle_pkg::CH_LOW_H) ? 3'd1 : 3'd0;
            end
            hle_pkg::PH_VSTART:
            begin
                if (page_byte == hle_pkg::CH_DQUOTE)
                begin
                    quote_next = hle_pkg::QM_DOUBLE;
                    phase_next = hle_pkg::PH_VALUE;
                end
                else if (page_byte == hle_pkg::CH_SQUOTE)
                begin
                    quote_next = hle_pkg::QM_SINGLE;
                    phase_next = hle_pkg::PH_VALUE;
                end
                else if (page_byte == hle_pkg::CH_GT)
                begin
                    rv       = 1'b1;
                    eol      = 1'b1;
                    idle_now = 1'b1;
                end
                else
                begin
                    quote_next = hle_pkg::QM_NONE;
                    rv         = 1'b1;
                    hb         = 1'b1;
                    lb         = page_byte;
                    len_next   = hle_pkg::LEN_W'(1);
                    phase_next = hle_pkg::PH_VALUE;
                    if (hle_pkg::LEN_W'(1) >= limit)
                    begin
                        eol      = 1'b1;
                        tr       = 1'b1;
                        idle_now = 1'b1;
                    end
                end
            end
            hle_pkg::PH_VALUE:
            begin
                closer = (quote_reg == hle_pkg::QM_DOUBLE && page_byte == hle_pkg::CH_DQUOTE)
                      || (quote_reg == hle_pkg::QM_SINGLE && page_byte == hle_pkg::CH_SQUOTE)
                      || (quote_reg != hle_pkg::QM_DOUBLE && quote_reg != hle_pkg::QM_SINGLE
                          && page_byte == hle_pkg::CH_GT);
                if (closer)
                begin
                    rv       = 1'b1;
                    eol      = 1'b1;
                    idle_now = 1'b1;
                end
                else
                begin
                    rv       = 1'b1;
                    hb       = 1'b1;
                    lb       = page_byte;
                    len_next = len_reg + hle_pkg::LEN_W'(1);
                    if (len_reg + hle_pkg::LEN_W'(1) >= limit)
                    begin
                        eol      = 1'b1;
                        tr       = 1'b1;
                        idle_now = 1'b1;
                    end
                end
            end
            default:
                idle_now = 1'b1;
        endcase

        // Page end: close a link still open after this byte.
        if (end_of_page)
        begin
            if (!idle_now && (phase_next == hle_pkg::PH_VSTART
                              || phase_next == hle_pkg::PH_VALUE))
            begin
                rv  = 1'b1;
                eol = 1'b1;
                tr  = 1'b1;
            end
            idle_now = 1'b1;
        end

        if (idle_now)
        begin
            phase_next    = hle_pkg::PH_IDLE;
            name_cnt_next = 3'd0;
            attr_cnt_next = 3'd0;
            quote_next    = hle_pkg::QM_NONE;
            len_next      = '0;
        end
    end

    assign res_valid       = accept && rv;
    assign res.link_byte   = lb;
    assign res.has_byte    = hb;
    assign res.end_of_link = eol;
    assign res.tag_kind    = kind_next;
    assign res.truncated   = tr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hle_pkg::PH_IDLE;
            name_cnt_reg <= 3'd0;
            attr_cnt_reg <= 3'd0;
            quote_reg    <= hle_pkg::QM_NONE;
            kind_reg     <= 1'b0;
            len_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            name_cnt_reg <= name_cnt_next;
            attr_cnt_reg <= attr_cnt_next;
            quote_reg    <= quote_next;
            kind_reg     <= kind_next;
            len_reg      <= len_next;
        end
    end

endmodule

// ----- rtl/html_href_link_extractor.sv -----
// Top level of the href link extractor: config registers, scanner, output queue.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, page_byte, end_of_page | to block
//  out     | out_valid, out_stall, link_byte, has_byte,  | from block
//          | end_of_link, tag_kind, truncated           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | to block
//
// One page byte per cycle while in_stall is low. The scanner state update is
// the only loop. A two-entry output queue (output register plus skid) registers
// each result beat and keeps input flowing while the sink stalls; in_stall
// rises only when the skid entry is full. Reset clears the control state and
// loads max_link_length=1023, tag_enable=3.
module html_href_link_extractor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                page_byte,
    input  logic                      end_of_page,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                link_byte,
    output logic                      has_byte,
    output logic                      end_of_link,
    output logic                      tag_kind,
    output logic                      truncated,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [hle_pkg::LEN_W-1:0] cfg_data
);

    logic [hle_pkg::LEN_W-1:0] max_len_reg;
    logic [1:0]                tag_en_reg;

    logic             in_accept;
    logic             res_valid;
    hle_pkg::result_t res;

    logic             out_valid_reg;
    hle_pkg::result_t out_reg;
    logic             skid_valid_reg;
    hle_pkg::result_t skid_reg;
    logic             out_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hle_pkg::LEN_W'(1023);
            tag_en_reg  <= 2'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hle_pkg::REG_MAX_LINK_LENGTH: max_len_reg <= cfg_data;
                hle_pkg::REG_TAG_ENABLE:      tag_en_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    hle_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .page_byte       (page_byte),
        .end_of_page     (end_of_page),
        .max_link_length (max_len_reg),
        .tag_enable      (tag_en_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            // Advance: skid entry moves up first to keep beat order.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end
            else
                out_valid_reg  <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
                out_reg  <= res;
        end
        else if (res_valid)
            skid_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign link_byte   = out_reg.link_byte;
    assign has_byte    = out_reg.has_byte;
    assign end_of_link = out_reg.end_of_link;
    assign tag_kind    = out_reg.tag_kind;
    assign truncated   = out_reg.truncated;

endmodule
